// ----- hdl/sitoa_pkg.sv -----
// Shared types, constants and the microcode table for the signed integer to
// decimal ASCII converter. No dependencies.
package sitoa_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int NUM_DIGITS        = 10;
   localparam int DIGIT_INDEX_WIDTH = 4;
   localparam int SHIFT_COUNT_WIDTH = 5;
   localparam int PC_WIDTH          = 2;

   localparam logic [SHIFT_COUNT_WIDTH-1:0] SHIFT_LAST = SHIFT_COUNT_WIDTH'(VALUE_WIDTH - 1);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Microcode step addresses
   localparam logic [PC_WIDTH-1:0] STEP_LOAD  = 2'd0;
   localparam logic [PC_WIDTH-1:0] STEP_SHIFT = 2'd1;
   localparam logic [PC_WIDTH-1:0] STEP_SIGN  = 2'd2;
   localparam logic [PC_WIDTH-1:0] STEP_DIGIT = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SHIFT = 2'd1,
      OP_SIGN  = 2'd2,
      OP_DIGIT = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PC_WIDTH-1:0] loop_target;
      logic [PC_WIDTH-1:0] exit_target;
   } ctrl_word_type;

   typedef struct packed {
      logic go;    // current step may complete this cycle
      logic done;  // take exit target instead of loop target
   } status_type;

   // Read-only control store: one word per step
   function automatic ctrl_word_type microcode(input logic [PC_WIDTH-1:0] pc);
      ctrl_word_type word;
      begin
         case (pc)
            STEP_LOAD:  word = '{op: OP_LOAD,  loop_target: STEP_LOAD,  exit_target: STEP_SHIFT};
            STEP_SHIFT: word = '{op: OP_SHIFT, loop_target: STEP_SHIFT, exit_target: STEP_SIGN};
            STEP_SIGN:  word = '{op: OP_SIGN,  loop_target: STEP_SIGN,  exit_target: STEP_DIGIT};
            STEP_DIGIT: word = '{op: OP_DIGIT, loop_target: STEP_DIGIT, exit_target: STEP_LOAD};
            default:    word = '{op: OP_LOAD,  loop_target: STEP_LOAD,  exit_target: STEP_SHIFT};
         endcase
         return word;
      end
   endfunction

endpackage

// ----- hdl/sitoa_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sitoa_pkg.
module sitoa_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  sitoa_pkg::status_type   status,
   output sitoa_pkg::ctrl_word_type ctrl
);

   logic [sitoa_pkg::PC_WIDTH-1:0] pc_ff;
   logic [sitoa_pkg::PC_WIDTH-1:0] pc_in;

   assign ctrl = sitoa_pkg::microcode(pc_ff);

   // hold while the step waits, else loop or exit
   always_comb begin
      pc_in = pc_ff;
      if (status.go) begin
         pc_in = status.done ? ctrl.exit_target : ctrl.loop_target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sitoa_pkg::STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- hdl/sitoa_dp.sv -----
// Datapath: magnitude and BCD registers with shift-add-3 conversion, digit
// pointer and the result register. Depends on sitoa_pkg.
module sitoa_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  sitoa_pkg::ctrl_word_type ctrl,
   output sitoa_pkg::status_type    status,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_character,
   output logic                     rsp_last_char
);

   localparam int VW = sitoa_pkg::VALUE_WIDTH;
   localparam int ND = sitoa_pkg::NUM_DIGITS;

   logic [VW-1:0]                              mag_ff, mag_in;
   logic [ND-1:0][3:0]                         bcd_ff, bcd_in;
   logic [ND-1:0][3:0]                         bcd_adj;
   logic [sitoa_pkg::SHIFT_COUNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [sitoa_pkg::DIGIT_INDEX_WIDTH-1:0]    idx_ff, idx_in;
   logic [sitoa_pkg::DIGIT_INDEX_WIDTH-1:0]    lead_idx;
   logic                                       neg_ff, neg_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                                 rsp_char_ff, rsp_char_in;
   logic                                       rsp_last_ff, rsp_last_in;
   logic [VW-1:0]                              raw;
   logic                                       out_free;
   logic                                       emit;

   assign raw      = req_value;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (ctrl.op != sitoa_pkg::OP_LOAD);

   // add 3 to every digit at five or above before the shift
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // highest nonzero digit, zero when the whole number is zero
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < ND; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            lead_idx = sitoa_pkg::DIGIT_INDEX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      status.go   = 1'b0;
      status.done = 1'b1;
      case (ctrl.op)
         sitoa_pkg::OP_LOAD: begin
            status.go = req_valid;
         end
         sitoa_pkg::OP_SHIFT: begin
            status.go   = 1'b1;
            status.done = (cnt_ff == sitoa_pkg::SHIFT_LAST);
         end
         sitoa_pkg::OP_SIGN: begin
            status.go = !neg_ff || out_free;
         end
         sitoa_pkg::OP_DIGIT: begin
            status.go   = out_free;
            status.done = (idx_ff == '0);
         end
         default: begin
            status.go = 1'b0;
         end
      endcase
   end

   always_comb begin
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      neg_in      = neg_ff;
      emit        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      case (ctrl.op)
         sitoa_pkg::OP_LOAD: begin
            if (req_valid) begin
               neg_in = raw[VW-1];
               mag_in = raw[VW-1] ? (~raw + VW'(1)) : raw;
               bcd_in = '0;
               cnt_in = '0;
            end
         end
         sitoa_pkg::OP_SHIFT: begin
            // shift the whole BCD vector left, magnitude MSB enters at the bottom
            bcd_in = {bcd_adj[ND-1][2:0], bcd_adj[ND-2:0], mag_ff[VW-1]};
            mag_in = {mag_ff[VW-2:0], 1'b0};
            cnt_in = cnt_ff + sitoa_pkg::SHIFT_COUNT_WIDTH'(1);
         end
         sitoa_pkg::OP_SIGN: begin
            idx_in = lead_idx;
            if (neg_ff && out_free) begin
               emit        = 1'b1;
               rsp_char_in = sitoa_pkg::ASCII_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         sitoa_pkg::OP_DIGIT: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_char_in = sitoa_pkg::ASCII_ZERO + {4'd0, bcd_ff[idx_ff]};
               rsp_last_in = (idx_ff == '0);
               idx_in      = idx_ff - sitoa_pkg::DIGIT_INDEX_WIDTH'(1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitoa_pkg, sitoa_seq and sitoa_dp.
//
// Each request carries one signed 32-bit value; the block answers with its
// decimal text, one ASCII character per response, most significant first,
// with a leading '-' for negative values and rsp_last_char set on the final
// digit. Zero gives the single character '0'; the most negative value gives
// "-2147483648". A short microcode program drives the datapath: one step
// takes the request and forms the unsigned magnitude, one step runs 32
// times to build ten BCD digits by shift-and-add-3, one step finds the
// leading digit and sends the sign, and one step repeats to send each digit.
// The sign rides in the step that finds the leading digit, and the block
// takes no new request until its last digit has been sent. Responses leave
// through an output register, so the last character can wait on rsp_stall
// while the next request is taken and converted. No state is kept between
// requests.
module signed_int_to_decimal_ascii (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [31:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_character,
   output logic              rsp_last_char
);

   sitoa_pkg::ctrl_word_type ctrl;
   sitoa_pkg::status_type    status;

   // step counter and control store
   sitoa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // conversion registers and response register
   sitoa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

endmodule
